// ----- hdl/md5br_pkg.sv -----
`default_nettype none

package md5br_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumMsg  = 16;
  localparam int unsigned NumStep = 64;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumMsg-1:0][WordW-1:0] msg_t;

  // working values plus the message block that rides along with them
  typedef struct packed {
    msg_t  msg;
    word_t d;
    word_t c;
    word_t b;
    word_t a;
  } stage_t;

  localparam word_t SineK [NumStep] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, row is the round, column the step within a group of four
  localparam logic [4:0] RotAmt [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

  localparam logic [1:0] RndF = 2'd0;
  localparam logic [1:0] RndG = 2'd1;
  localparam logic [1:0] RndH = 2'd2;
  localparam logic [1:0] RndI = 2'd3;

  function automatic word_t rotl(word_t x, logic [4:0] s);
    logic [2*WordW-1:0] dbl;
    dbl = {x, x} << s;
    return dbl[2*WordW-1:WordW];
  endfunction

  function automatic word_t mix(logic [1:0] rnd, word_t x, word_t y, word_t z);
    word_t r;
    case (rnd)
      RndF:    r = (x & y) | (~x & z);
      RndG:    r = (x & z) | (y & ~z);
      RndH:    r = x ^ y ^ z;
      default: r = y ^ (x | ~z);
    endcase
    return r;
  endfunction

  function automatic logic [3:0] word_idx(logic [1:0] rnd, logic [3:0] i);
    logic [3:0] r;
    case (rnd)
      RndF:    r = i;
      RndG:    r = 4'((i << 2) + i + 4'd1);
      RndH:    r = 4'((i << 1) + i + 4'd5);
      default: r = 4'((i << 3) - i);
    endcase
    return r;
  endfunction

  // one md5 step, the working values shift by one place
  function automatic stage_t md5_step(logic [5:0] step, stage_t s);
    stage_t     r;
    logic [1:0] rnd;
    word_t      sum;
    rnd   = step[5:4];
    sum   = s.a + mix(rnd, s.b, s.c, s.d) + s.msg[word_idx(rnd, step[3:0])]
            + SineK[step];
    r     = s;
    r.a   = s.d;
    r.d   = s.c;
    r.c   = s.b;
    r.b   = s.b + rotl(sum, RotAmt[rnd][step[1:0]]);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/md5br_stage.sv -----
`default_nettype none

module md5br_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  [5:0]           step_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire md5br_pkg::stage_t in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output md5br_pkg::stage_t    out_data_o
);
  import md5br_pkg::*;

  logic   valid_q;
  stage_t data_q;
  stage_t data_d;

  // a bubble here may be filled even while later stages stall
  assign in_ready_o = !valid_q || out_ready_i;
  assign data_d     = md5_step(step_i, in_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ----- hdl/md5_block_rounds.sv -----
`default_nettype none

// md5 compression core without the final feed-forward add. each of the 64
// steps has its own register stage, so a block enters in every cycle in
// which s_axis_tready is high, and its four working values leave from the
// last step's register, which is the output register. a stage holding a
// bubble takes new data even while the stages after it stall, so the block
// keeps accepting words until every stage is full and the output is not
// taken. the ready path runs through the per-stage ready logic of all 64
// stages. no reset-time sweep; reset only clears the valid bits.
module md5_block_rounds (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // a_in[31:0], b_in, c_in, d_in, msg_pair_0 .. msg_pair_7 (64 bits each)
  input  wire  [639:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // a_out[31:0], b_out, c_out, d_out
  output logic [127:0] m_axis_tdata
);
  import md5br_pkg::*;

  stage_t              pipe_data [NumStep+1];
  logic [NumStep:0]    pipe_valid;
  logic [NumStep:0]    pipe_ready;

  // input word splits straight into working values and message words
  assign pipe_data[0].a   = s_axis_tdata[31:0];
  assign pipe_data[0].b   = s_axis_tdata[63:32];
  assign pipe_data[0].c   = s_axis_tdata[95:64];
  assign pipe_data[0].d   = s_axis_tdata[127:96];
  assign pipe_data[0].msg = s_axis_tdata[639:128];
  assign pipe_valid[0]    = s_axis_tvalid;
  assign s_axis_tready    = pipe_ready[0];

  for (genvar g = 0; g < NumStep; g++) begin : g_step
    md5br_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (6'(g)),
      .in_valid_i  (pipe_valid[g]),
      .in_ready_o  (pipe_ready[g]),
      .in_data_i   (pipe_data[g]),
      .out_valid_o (pipe_valid[g+1]),
      .out_ready_i (pipe_ready[g+1]),
      .out_data_o  (pipe_data[g+1])
    );
  end

  assign pipe_ready[NumStep] = m_axis_tready;
  assign m_axis_tvalid       = pipe_valid[NumStep];
  assign m_axis_tdata        = {pipe_data[NumStep].d, pipe_data[NumStep].c,
                                pipe_data[NumStep].b, pipe_data[NumStep].a};

  // assertions

  logic in_acc;
  logic out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // the input only stalls when every stage holds a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&pipe_valid[NumStep:1]))
    else $error("input stalled with a bubble in the pipeline");

  // an accepted word always lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pipe_valid[1])
    else $error("accepted word did not enter the first stage");

  // words in flight change only by what enters and what leaves
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ($countones(pipe_valid[NumStep:1]) ==
         $past($countones(pipe_valid[NumStep:1])) + $past(32'(in_acc))
         - $past(32'(out_acc))))
    else $error("word lost or duplicated in the pipeline");

endmodule

`default_nettype wire
